// ===== sv/smi_pkg.sv =====
// Shared types, constants and saturating helpers for the surface moment integrator.
// No dependencies; smi_mac and surface_moment_integrator import this package.
`default_nettype none

package smi_pkg;

  // Q32.32 accumulator word
  typedef logic signed [63:0] q64_t;

  localparam q64_t Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q64_t Q64_MIN = 64'sh8000_0000_0000_0000;

  // shared multiplier operand widths
  localparam int OPA_W  = 35;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 128;

  // one row-store entry holds three corner values
  localparam int CORNER_W = 3 * 64;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CELL_CENTERED = 3'd0,
    REG_TWO_DIM       = 3'd1,
    REG_ROW_LENGTH    = 3'd2,
    REG_CENTER_X      = 3'd3,
    REG_CENTER_Y      = 3'd4,
    REG_CENTER_Z      = 3'd5
  } reg_idx_t;

  // floor shift applied to a finished product
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_17 = 2'd2,
    SH_18 = 2'd3
  } shift_t;

  // tag that travels with each partial product through the multiplier
  typedef struct packed {
    logic       valid;
    logic       first;  // clear the accumulator
    logic       hi;     // partial product weighs 2^32
    logic       last;   // last partial of a term
    logic [2:0] term;
    shift_t     sh;
  } mac_tag_t;

  function automatic q64_t sat_fix(input logic signed [64:0] v);
    if (v[64] != v[63]) begin
      sat_fix = v[64] ? Q64_MIN : Q64_MAX;
    end else begin
      sat_fix = v[63:0];
    end
  endfunction

  function automatic q64_t sat_add64(input q64_t a, input q64_t b);
    sat_add64 = sat_fix({a[63], a} + {b[63], b});
  endfunction

  function automatic q64_t sat_sub64(input q64_t a, input q64_t b);
    sat_sub64 = sat_fix({a[63], a} - {b[63], b});
  endfunction

  // cross product term order: x = v1*f2 - v2*f1, y = v2*f0 - v0*f2, z = v0*f1 - v1*f0
  function automatic logic [1:0] cross_v(input logic [2:0] t);
    case (t)
      3'd0:    cross_v = 2'd1;
      3'd1:    cross_v = 2'd2;
      3'd2:    cross_v = 2'd2;
      3'd3:    cross_v = 2'd0;
      3'd4:    cross_v = 2'd0;
      default: cross_v = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] cross_f(input logic [2:0] t);
    case (t)
      3'd0:    cross_f = 2'd2;
      3'd1:    cross_f = 2'd1;
      3'd2:    cross_f = 2'd0;
      3'd3:    cross_f = 2'd2;
      3'd4:    cross_f = 2'd1;
      default: cross_f = 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/smi_in_if.sv =====
// Node input channel: valid/ready handshake plus one mesh node word.
// Depends on nothing.
`default_nettype none

interface smi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] weight;
  logic        [30:0] cell_size;
  logic               last;

  modport source (
    output valid, pos_x, pos_y, pos_z, force_x, force_y, force_z, weight, cell_size, last,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, force_x, force_y, force_z, weight, cell_size, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/smi_out_if.sv =====
// Result channel: valid/ready handshake plus the integrated moment word.
// Depends on nothing.
`default_nettype none

interface smi_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] moment_x;
  logic signed [63:0] moment_y;
  logic signed [63:0] moment_z;

  modport source (output valid, moment_x, moment_y, moment_z, input ready);
  modport sink   (input  valid, moment_x, moment_y, moment_z, output ready);
endinterface

`default_nettype wire

// ===== sv/smi_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`default_nettype none

interface smi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/smi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smi_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/smi_mac.sv =====
// Shared multiplier with a 128-bit accumulator, floor shift and 64-bit saturation.
// Depends on smi_pkg.
`default_nettype none

module smi_mac import smi_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_tag_t                 tag_in,
  input  wire logic signed [OPA_W-1:0]  op_a,
  input  wire logic signed [OPB_W-1:0]  op_b,
  output mac_tag_t                      tag_out,
  output q64_t                          result
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  pext;
  logic signed [ACC_W-1:0]  shd;
  mac_tag_t                 tag1_r;
  mac_tag_t                 tag2_r;

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  // stage 1: product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // stage 2: accumulate, upper partials weigh 2^32
  always_comb begin
    pext    = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    acc_nxt = (tag1_r.first ? '0 : acc_r) + (tag1_r.hi ? (pext <<< 32) : pext);
  end

  always_ff @(posedge clk) begin
    if (tag1_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // floor shift and saturate
  always_comb begin
    case (tag2_r.sh)
      SH_0:    shd = acc_r;
      SH_16:   shd = acc_r >>> 16;
      SH_17:   shd = acc_r >>> 17;
      default: shd = acc_r >>> 18;
    endcase
    if ((&shd[ACC_W-1:63]) || !(|shd[ACC_W-1:63])) begin
      result = shd[63:0];
    end else begin
      result = shd[ACC_W-1] ? Q64_MIN : Q64_MAX;
    end
  end

  assign tag_out = tag2_r;

endmodule

`default_nettype wire

// ===== sv/surface_moment_integrator.sv =====
// Surface moment integrator: takes structured-mesh nodes in raster order and
// accumulates the moment (position - center) x (weight * force) of every
// completed cell into three saturating Q32.32 sums, reported once on the node
// marked last. One node is worked on at a time: it is accepted, then up to 21
// partial products go through one shared 35x33-bit multiplier, with row-store
// reads, sums and write-backs between the multiplier jobs. The previous grid
// row lives in a MAX_ROW-entry row store (one read and one write port). A
// result waits in an output register; a write to any of the six configuration
// registers restarts the grid and is taken only between nodes, ahead of a node
// word offered in the same cycle.
// Depends on smi_pkg, smi_in_if, smi_out_if, smi_cfg_if, smi_ram and smi_mac.
`default_nettype none

module surface_moment_integrator import smi_pkg::*; #(
  parameter int MAX_ROW = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  smi_in_if.sink     in_ch,
  smi_out_if.source  out_ch,
  smi_cfg_if.sink    cfg_ch
);

  localparam int AW  = $clog2(MAX_ROW);
  localparam int CW  = $clog2(MAX_ROW + 1);
  localparam int RW  = (CW > 11) ? CW : 11;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_FMUL   = 11'b000_0000_0010,
    S_NCROSS = 11'b000_0000_0100,
    S_RDA    = 11'b000_0000_1000,
    S_RDB    = 11'b000_0001_0000,
    S_RDC    = 11'b000_0010_0000,
    S_SUM    = 11'b000_0100_0000,
    S_WRC    = 11'b000_1000_0000,
    S_CCROSS = 11'b001_0000_0000,
    S_SCALE  = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic               cell_r;
  logic               two_d_r;
  logic [10:0]        row_len_r;
  logic signed [31:0] center_r [3];

  // grid state
  logic [AW-1:0]      column_count_r;
  logic               first_row_r;
  q64_t               left_r [3];
  q64_t               sum_r  [3];

  // current node
  logic signed [31:0] w_r;
  logic signed [31:0] force_r [3];
  logic [30:0]        size_r;
  logic               last_r;
  logic signed [32:0] d_r [3];
  logic [AW-1:0]      col_r;
  logic               last_col_r;
  logic [RW-1:0]      r_r;
  logic               complete_r;
  q64_t               f_r      [3];
  q64_t               corner_r [3];
  q64_t               tmp_r;
  q64_t               arow_r   [3];
  q64_t               brow_r   [3];
  q64_t               s_r      [3];
  q64_t               m_r      [3];

  // output register
  logic               out_valid_r;
  q64_t               out_m_r [3];

  logic               in_acc, cfg_acc, out_free, col_nz, need_rd;
  logic               job_done, cap;
  logic [3:0]         iss_r;
  logic [3:0]         iss_max;
  logic [2:0]         job_last;
  logic [1:0]         vi, fj, sk;
  logic signed [32:0] d_nxt [3];
  logic [RW-1:0]      rl_ext, r_eff, col_ext, col_eff, nc;
  q64_t               s_nxt [3];

  mac_tag_t                tag_in, tag_out;
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  q64_t                    mac_res;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CORNER_W-1:0]  ram_wdata, ram_rdata;

  // handshakes; a register write goes ahead of a node word
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.moment_x = out_m_r[0];
  assign out_ch.moment_y = out_m_r[1];
  assign out_ch.moment_z = out_m_r[2];

  assign col_nz  = (col_r != '0);
  assign need_rd = two_d_r && col_nz && !first_row_r;

  // offsets from the center and row position of the incoming node
  always_comb begin
    d_nxt[0] = {in_ch.pos_x[31], in_ch.pos_x} - {center_r[0][31], center_r[0]};
    d_nxt[1] = {in_ch.pos_y[31], in_ch.pos_y} - {center_r[1][31], center_r[1]};
    d_nxt[2] = {in_ch.pos_z[31], in_ch.pos_z} - {center_r[2][31], center_r[2]};
    rl_ext   = RW'(row_len_r);
    if (rl_ext < RW'(2)) begin
      r_eff = RW'(2);
    end else if (rl_ext > RW'(MAX_ROW)) begin
      r_eff = RW'(MAX_ROW);
    end else begin
      r_eff = rl_ext;
    end
    col_ext = RW'(column_count_r);
    col_eff = (col_ext >= r_eff) ? '0 : col_ext;
    nc      = RW'(col_r) + RW'(1);
  end

  // corner sums of the completed cell
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (two_d_r) begin
        s_nxt[k] = sat_add64(sat_add64(arow_r[k], brow_r[k]),
                             sat_add64(left_r[k], corner_r[k]));
      end else begin
        s_nxt[k] = sat_add64(left_r[k], corner_r[k]);
      end
    end
  end

  // multiplier issue
  always_comb begin
    tag_in   = '0;
    op_a     = '0;
    op_b     = '0;
    iss_max  = 4'd0;
    job_last = 3'd0;
    vi       = cross_v(iss_r[3:1]);
    fj       = cross_f(iss_r[3:1]);
    sk       = iss_r[2:1];
    case (state_r)
      S_FMUL: begin
        iss_max  = 4'd3;
        job_last = 3'd2;
        if (iss_r < iss_max) begin
          tag_in.valid = 1'b1;
          tag_in.first = 1'b1;
          tag_in.last  = 1'b1;
          tag_in.term  = iss_r[2:0];
          tag_in.sh    = SH_0;
          op_a = {{(OPA_W-32){w_r[31]}}, w_r};
          op_b = {force_r[iss_r[1:0]][31], force_r[iss_r[1:0]]};
        end
      end
      S_NCROSS, S_CCROSS: begin
        iss_max  = 4'd12;
        job_last = 3'd5;
        if (iss_r < iss_max) begin
          tag_in.valid = 1'b1;
          tag_in.first = !iss_r[0];
          tag_in.hi    = iss_r[0];
          tag_in.last  = iss_r[0];
          tag_in.term  = iss_r[3:1];
          tag_in.sh    = SH_16;
          if (state_r == S_NCROSS) begin
            op_a = {{(OPA_W-33){d_r[vi][32]}}, d_r[vi]};
          end else begin
            op_a = s_r[vi][OPA_W-1:0];
          end
          op_b = iss_r[0] ? {f_r[fj][63], f_r[fj][63:32]} : {1'b0, f_r[fj][31:0]};
        end
      end
      S_SCALE: begin
        iss_max  = 4'd6;
        job_last = 3'd2;
        if (iss_r < iss_max) begin
          tag_in.valid = 1'b1;
          tag_in.first = !iss_r[0];
          tag_in.hi    = iss_r[0];
          tag_in.last  = iss_r[0];
          tag_in.term  = {1'b0, sk};
          tag_in.sh    = two_d_r ? SH_18 : SH_17;
          op_a = iss_r[0] ? {{(OPA_W-32){m_r[sk][63]}}, m_r[sk][63:32]}
                          : {{(OPA_W-32){1'b0}}, m_r[sk][31:0]};
          op_b = {2'b00, size_r};
        end
      end
      default: ;
    endcase
  end

  assign cap      = tag_out.valid && tag_out.last;
  assign job_done = cap && (tag_out.term == job_last);

  smi_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag_in),
    .op_a    (op_a),
    .op_b    (op_b),
    .tag_out (tag_out),
    .result  (mac_res)
  );

  // row store: read both corners above, write back the left node and row end
  always_comb begin
    ram_raddr = (state_r == S_RDA) ? (col_r - AW'(1)) : col_r;
    ram_we    = 1'b0;
    ram_waddr = col_r;
    ram_wdata = {corner_r[2], corner_r[1], corner_r[0]};
    if (state_r == S_SUM && two_d_r && col_nz) begin
      ram_we    = 1'b1;
      ram_waddr = col_r - AW'(1);
      ram_wdata = {left_r[2], left_r[1], left_r[0]};
    end else if (state_r == S_WRC && two_d_r && last_col_r) begin
      ram_we    = 1'b1;
    end
  end

  smi_ram #(
    .WIDTH (CORNER_W),
    .DEPTH (MAX_ROW)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_FMUL;
      S_FMUL: begin
        if (job_done) begin
          if (!cell_r)      state_nxt = S_NCROSS;
          else if (need_rd) state_nxt = S_RDA;
          else              state_nxt = S_SUM;
        end
      end
      S_NCROSS: if (job_done) state_nxt = need_rd ? S_RDA : S_SUM;
      S_RDA:    state_nxt = S_RDB;
      S_RDB:    state_nxt = S_RDC;
      S_RDC:    state_nxt = S_SUM;
      S_SUM:    state_nxt = S_WRC;
      S_WRC: begin
        if (!complete_r)  state_nxt = S_FIN;
        else if (cell_r)  state_nxt = S_CCROSS;
        else              state_nxt = S_SCALE;
      end
      S_CCROSS: if (job_done) state_nxt = S_SCALE;
      S_SCALE:  if (job_done) state_nxt = S_FIN;
      S_FIN:    if (!last_r || out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control, configuration, grid state and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      iss_r          <= '0;
      cell_r         <= 1'b0;
      two_d_r        <= 1'b1;
      row_len_r      <= 11'd2;
      center_r[0]    <= '0;
      center_r[1]    <= '0;
      center_r[2]    <= '0;
      column_count_r <= '0;
      first_row_r    <= 1'b1;
      out_valid_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        left_r[k] <= '0;
        sum_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // issue counter of the current multiplier job
      if (job_done) begin
        iss_r <= '0;
      end else if (iss_r < iss_max) begin
        iss_r <= iss_r + 4'd1;
      end

      // sums take each scaled cell term
      if (state_r == S_SCALE && cap) begin
        sum_r[tag_out.term[1:0]] <= sat_add64(sum_r[tag_out.term[1:0]], mac_res);
      end

      // output word valid
      if (state_r == S_FIN && state_nxt == S_IDLE && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // end of node: advance the grid, or report and restart
      if (state_r == S_FIN && state_nxt == S_IDLE) begin
        if (last_r) begin
          column_count_r <= '0;
          first_row_r    <= 1'b1;
          for (int k = 0; k < 3; k++) begin
            left_r[k] <= '0;
            sum_r[k]  <= '0;
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            left_r[k] <= corner_r[k];
          end
          if (!two_d_r) begin
            column_count_r <= AW'(1);
          end else if (nc >= r_r) begin
            column_count_r <= '0;
            first_row_r    <= 1'b0;
          end else begin
            column_count_r <= AW'(nc);
          end
        end
      end

      // writes to the six registers restart the grid
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_CELL_CENTERED: cell_r      <= cfg_ch.data[0];
          REG_TWO_DIM:       two_d_r     <= cfg_ch.data[0];
          REG_ROW_LENGTH:    row_len_r   <= cfg_ch.data[10:0];
          REG_CENTER_X:      center_r[0] <= cfg_ch.data;
          REG_CENTER_Y:      center_r[1] <= cfg_ch.data;
          REG_CENTER_Z:      center_r[2] <= cfg_ch.data;
          default: ;
        endcase
        if (cfg_ch.index <= REG_CENTER_Z) begin
          column_count_r <= '0;
          first_row_r    <= 1'b1;
          for (int k = 0; k < 3; k++) begin
            left_r[k] <= '0;
            sum_r[k]  <= '0;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // node word
    if (in_acc) begin
      w_r        <= in_ch.weight;
      force_r[0] <= in_ch.force_x;
      force_r[1] <= in_ch.force_y;
      force_r[2] <= in_ch.force_z;
      size_r     <= in_ch.cell_size;
      last_r     <= in_ch.last;
      col_r      <= AW'(col_eff);
      last_col_r <= (col_eff == r_eff - RW'(1));
      r_r        <= r_eff;
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= d_nxt[k];
        if (cell_r) begin
          corner_r[k] <= {{31{d_nxt[k][32]}}, d_nxt[k]};
        end
      end
    end

    // multiplier results
    if (cap) begin
      case (state_r)
        S_FMUL: f_r[tag_out.term[1:0]] <= mac_res;
        S_NCROSS: begin
          if (!tag_out.term[0]) begin
            tmp_r <= mac_res;
          end else begin
            corner_r[tag_out.term[2:1]] <= sat_sub64(tmp_r, mac_res);
          end
        end
        S_CCROSS: begin
          if (!tag_out.term[0]) begin
            tmp_r <= mac_res;
          end else begin
            m_r[tag_out.term[2:1]] <= sat_sub64(tmp_r, mac_res);
          end
        end
        default: ;
      endcase
    end

    // row-store read data
    if (state_r == S_RDB) begin
      for (int k = 0; k < 3; k++) arow_r[k] <= ram_rdata[64*k +: 64];
    end
    if (state_r == S_RDC) begin
      for (int k = 0; k < 3; k++) brow_r[k] <= ram_rdata[64*k +: 64];
    end

    // corner sums; in node mode they are the cell moment
    if (state_r == S_SUM) begin
      complete_r <= two_d_r ? (col_nz && !first_row_r) : (column_count_r != '0);
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= s_nxt[k];
        m_r[k] <= s_nxt[k];
      end
    end

    // result word
    if (state_r == S_FIN && state_nxt == S_IDLE && last_r) begin
      for (int k = 0; k < 3; k++) out_m_r[k] <= sum_r[k];
    end
  end

endmodule

`default_nettype wire
